// ----- design/imp_pkg.sv -----
// imp_pkg: shared types, register codes and helpers for the imu measurement predictor
// no dependencies; imported by every design file

package imp_pkg;

    typedef logic signed [15:0] t_q16;

    // one input item, body frame, signed q8.8
    typedef struct packed {
        t_q16 acc_x;
        t_q16 acc_y;
        t_q16 acc_z;
        t_q16 rate_x;
        t_q16 rate_y;
        t_q16 rate_z;
        t_q16 spin_acc_x;
        t_q16 spin_acc_y;
        t_q16 spin_acc_z;
    } t_in_item;

    // one result item, saturated signed q8.8
    typedef struct packed {
        t_q16 pred_acc_x;
        t_q16 pred_acc_y;
        t_q16 pred_acc_z;
        t_q16 pred_rate_x;
        t_q16 pred_rate_y;
        t_q16 pred_rate_z;
    } t_out_item;

    typedef struct packed {
        logic        base_mode;
        logic [47:0] position_offset;
        logic [63:0] mount_quaternion;
        logic [47:0] accel_bias;
        logic [47:0] gyro_bias;
    } t_cfg;

    // what one rotation unit needs
    typedef struct packed {
        logic        base_mode;
        logic [63:0] mount_quaternion;
        logic [47:0] bias;
    } t_rot_cfg;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [2:0] REG_BASE_MODE   = 3'd0;
    localparam logic [2:0] REG_POS_OFFSET  = 3'd1;
    localparam logic [2:0] REG_MOUNT_QUAT  = 3'd2;
    localparam logic [2:0] REG_ACCEL_BIAS  = 3'd3;
    localparam logic [2:0] REG_GYRO_BIAS   = 3'd4;

    localparam logic [63:0] QUAT_RESET = 64'h4000_0000_0000_0000;

    // width of the lever-arm corrected acceleration, q.16
    localparam int FW = 40;
    // width of the angular rate entering its rotation, q.16
    localparam int RW = 24;

    // element of a packed x,y,z vector, x in the high bits
    function automatic t_q16 vec_elem(input logic [47:0] v, input logic [1:0] idx);
        t_q16 e;
        case (idx)
            2'd0:    e = v[47:32];
            2'd1:    e = v[31:16];
            default: e = v[15:0];
        endcase
        return e;
    endfunction

endpackage

// ----- design/imp_lever.sv -----
// imp_lever: three stage lever-arm term a + alpha x r + w x (w x r), rounded to q.16
// depends on imp_pkg

module imp_lever
    import imp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output logic     o_valid,
    output logic signed [FW-1:0] o_f [3],
    output t_q16     o_acc [3],
    output t_q16     o_rate [3]
);

    localparam int SUM_W = FW + 12;

    t_q16 a [3];
    t_q16 w [3];
    t_q16 al [3];
    t_q16 r [3];

    assign a[0]  = i_item.acc_x;
    assign a[1]  = i_item.acc_y;
    assign a[2]  = i_item.acc_z;
    assign w[0]  = i_item.rate_x;
    assign w[1]  = i_item.rate_y;
    assign w[2]  = i_item.rate_z;
    assign al[0] = i_item.spin_acc_x;
    assign al[1] = i_item.spin_acc_y;
    assign al[2] = i_item.spin_acc_z;

    logic              r1_v, r2_v, r3_v;
    t_q16              r1_a [3], r1_w [3], r2_a [3], r2_w [3], r3_a [3], r3_w [3];
    logic signed [32:0] r1_wr [3], r1_ar [3], r2_ar [3];
    logic signed [32:0] n_wr [3], n_ar [3];
    logic signed [49:0] r2_wwr [3], n_wwr [3];
    logic signed [FW-1:0] r3_f [3], n_f [3];

    for (genvar i = 0; i < 3; i++) begin : g_elem
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        logic signed [31:0] p_wr0, p_wr1, p_ar0, p_ar1;
        logic signed [48:0] p_ww0, p_ww1;
        logic signed [SUM_W-1:0] ea, er, sum;

        assign r[i] = vec_elem(i_cfg.position_offset, 2'(i));

        // stage 1: w x r and alpha x r, q.20
        assign p_wr0   = w[J] * r[K];
        assign p_wr1   = w[K] * r[J];
        assign p_ar0   = al[J] * r[K];
        assign p_ar1   = al[K] * r[J];
        assign n_wr[i] = p_wr0 - p_wr1;
        assign n_ar[i] = p_ar0 - p_ar1;

        // stage 2: w x (w x r), q.28
        assign p_ww0    = r1_w[J] * r1_wr[K];
        assign p_ww1    = r1_w[K] * r1_wr[J];
        assign n_wwr[i] = p_ww0 - p_ww1;

        // stage 3: exact sum in q.28, round half up to q.16
        assign ea     = r2_a[i];
        assign er     = r2_ar[i];
        assign sum    = (ea <<< 20) + (er <<< 8) + r2_wwr[i] + (SUM_W'(1) <<< 11);
        assign n_f[i] = sum[SUM_W-1:12];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_a   <= a;
        r1_w   <= w;
        r1_wr  <= n_wr;
        r1_ar  <= n_ar;
        r2_a   <= r1_a;
        r2_w   <= r1_w;
        r2_ar  <= r1_ar;
        r2_wwr <= n_wwr;
        r3_a   <= r2_a;
        r3_w   <= r2_w;
        r3_f   <= n_f;
    end

    assign o_valid = r3_v;
    assign o_f     = r3_f;
    assign o_acc   = r3_a;
    assign o_rate  = r3_w;

endmodule

// ----- design/imp_rotate.sv -----
// imp_rotate: four stage quaternion rotation v + s*t + u x t, t = 2(u x v), plus bias and saturation
// depends on imp_pkg

module imp_rotate
    import imp_pkg::*;
#(
    parameter int VW = 24
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic signed [VW-1:0] i_v [3],
    input  t_q16     i_pass [3],
    input  t_rot_cfg i_cfg,
    output logic     o_valid,
    output t_q16     o_res [3]
);

    localparam int PW  = VW + 16;
    localparam int CW  = VW + 17;
    localparam int RDW = CW + 1;
    localparam int TW  = VW + 5;
    localparam int UPW = TW + 16;
    localparam int UW  = TW + 17;
    localparam int SW  = VW + 24;
    localparam int OW  = VW + 2;
    localparam int BW  = OW + 1;

    localparam logic signed [BW-1:0] SAT_HI = BW'(32767);
    localparam logic signed [BW-1:0] SAT_LO = BW'(-32768);

    t_q16 s;
    t_q16 u [3];

    assign s = i_cfg.mount_quaternion[63:48];

    logic                 r1_v, r2_v, r3_v, r4_v;
    logic signed [VW-1:0] r1_vv [3], r2_vv [3];
    t_q16                 r1_p [3], r2_p [3], r3_p [3], r4_res [3];
    logic signed [TW-1:0] r1_t [3], n_t [3];
    logic signed [UW-1:0] r2_ut [3], n_ut [3];
    logic signed [UPW-1:0] r2_st [3], n_st [3];
    logic signed [OW-1:0] r3_o [3], n_o [3];
    t_q16                 n_res [3];

    for (genvar i = 0; i < 3; i++) begin : g_elem
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        logic signed [PW-1:0]  p_c0, p_c1;
        logic signed [CW-1:0]  c;
        logic signed [RDW-1:0] rc;
        logic signed [UPW-1:0] p_u0, p_u1;
        logic signed [SW-1:0]  ev, sum;
        logic signed [BW-1:0]  y;

        assign u[i] = vec_elem(i_cfg.mount_quaternion[47:0], 2'(i));

        // stage 1: t = 2(u x v), q.30 product rounded to q.16
        assign p_c0   = u[J] * i_v[K];
        assign p_c1   = u[K] * i_v[J];
        assign c      = p_c0 - p_c1;
        assign rc     = c + (RDW'(1) <<< 12);
        assign n_t[i] = rc[RDW-1:13];

        // stage 2: u x t and s*t, q.30
        assign p_u0    = u[J] * r1_t[K];
        assign p_u1    = u[K] * r1_t[J];
        assign n_ut[i] = p_u0 - p_u1;
        assign n_st[i] = s * r1_t[i];

        // stage 3: exact q.30 sum, round half up to q.8
        assign ev     = r2_vv[i];
        assign sum    = (ev <<< 14) + r2_st[i] + r2_ut[i] + (SW'(1) <<< 21);
        assign n_o[i] = sum[SW-1:22];

        // stage 4: bias, saturate, pass-through select
        assign y = r3_o[i] + vec_elem(i_cfg.bias, 2'(i));

        always_comb begin
            if (i_cfg.base_mode) begin
                n_res[i] = r3_p[i];
            end else if (y > SAT_HI) begin
                n_res[i] = SAT_HI[15:0];
            end else if (y < SAT_LO) begin
                n_res[i] = SAT_LO[15:0];
            end else begin
                n_res[i] = y[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_vv  <= i_v;
        r1_p   <= i_pass;
        r1_t   <= n_t;
        r2_vv  <= r1_vv;
        r2_p   <= r1_p;
        r2_ut  <= n_ut;
        r2_st  <= n_st;
        r3_p   <= r2_p;
        r3_o   <= n_o;
        r4_res <= n_res;
    end

    assign o_valid = r4_v;
    assign o_res   = r4_res;

endmodule

// ----- design/imu_measurement_predict.sv -----
// imu_measurement_predict: top level, register file and the lever-arm and rotation pipelines
// depends on imp_pkg, imp_lever, imp_rotate
//
// channel   direction  handshake                         payload
// input     in         start high, busy low at the edge  i_item   (t_in_item)
// result    out        o_done high for one cycle         o_result (t_out_item)
// config    in/out     psel, penable, pwrite, pready     paddr, pwdata, prdata (64 bit)
//
// one item may enter every cycle; its result is taken from the output registers of the rotation pipelines
// the path is three lever-arm stages and four rotation stages, each at most one multiply deep
// busy never rises: the pipeline has no stall, the receiver takes every result
// reset clears the valid bits and loads the register reset values; payload is not reset
// registers sit at byte address 8 * index; the user writes only while no item is in flight, not enforced by the block

module imu_measurement_predict
    import imp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // item input
    input  logic              start,
    output logic              busy,
    input  t_in_item          i_item,
    // result output
    output logic              o_done,
    output t_out_item         o_result,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // register file
    t_cfg       r_cfg, n_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_BASE_MODE:  n_cfg.base_mode        = pwdata[0];
                REG_POS_OFFSET: n_cfg.position_offset  = pwdata[47:0];
                REG_MOUNT_QUAT: n_cfg.mount_quaternion = pwdata;
                REG_ACCEL_BIAS: n_cfg.accel_bias       = pwdata[47:0];
                REG_GYRO_BIAS:  n_cfg.gyro_bias        = pwdata[47:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_mode        <= 1'b0;
            r_cfg.position_offset  <= '0;
            r_cfg.mount_quaternion <= QUAT_RESET;
            r_cfg.accel_bias       <= '0;
            r_cfg.gyro_bias        <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read back, zero extended
    always_comb begin
        case (reg_idx)
            REG_BASE_MODE:  prdata = DATA_W'(r_cfg.base_mode);
            REG_POS_OFFSET: prdata = DATA_W'(r_cfg.position_offset);
            REG_MOUNT_QUAT: prdata = r_cfg.mount_quaternion;
            REG_ACCEL_BIAS: prdata = DATA_W'(r_cfg.accel_bias);
            REG_GYRO_BIAS:  prdata = DATA_W'(r_cfg.gyro_bias);
            default:        prdata = '0;
        endcase
    end

    // item intake, never held off
    assign busy = 1'b0;

    logic                 lv_valid;
    logic signed [FW-1:0] lv_f [3];
    t_q16                 lv_acc [3];
    t_q16                 lv_rate [3];

    imp_lever u_lever (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_valid (lv_valid),
        .o_f     (lv_f),
        .o_acc   (lv_acc),
        .o_rate  (lv_rate)
    );

    // rate enters its rotation as q.16
    logic signed [RW-1:0] rate_q16 [3];
    for (genvar i = 0; i < 3; i++) begin : g_rate
        assign rate_q16[i] = {lv_rate[i], 8'h00};
    end

    t_rot_cfg acc_cfg, gyr_cfg;
    assign acc_cfg = '{base_mode: r_cfg.base_mode,
                       mount_quaternion: r_cfg.mount_quaternion,
                       bias: r_cfg.accel_bias};
    assign gyr_cfg = '{base_mode: r_cfg.base_mode,
                       mount_quaternion: r_cfg.mount_quaternion,
                       bias: r_cfg.gyro_bias};

    logic acc_valid, gyr_valid;
    t_q16 acc_res [3];
    t_q16 gyr_res [3];

    // accelerometer path: lever-arm corrected acceleration
    imp_rotate #(.VW(FW)) u_rot_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lv_valid),
        .i_v     (lv_f),
        .i_pass  (lv_acc),
        .i_cfg   (acc_cfg),
        .o_valid (acc_valid),
        .o_res   (acc_res)
    );

    // gyro path: body rate
    imp_rotate #(.VW(RW)) u_rot_gyr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lv_valid),
        .i_v     (rate_q16),
        .i_pass  (lv_rate),
        .i_cfg   (gyr_cfg),
        .o_valid (gyr_valid),
        .o_res   (gyr_res)
    );

    // both paths run in lock step, results come from their output registers
    assign o_done               = acc_valid && gyr_valid;
    assign o_result.pred_acc_x  = acc_res[0];
    assign o_result.pred_acc_y  = acc_res[1];
    assign o_result.pred_acc_z  = acc_res[2];
    assign o_result.pred_rate_x = gyr_res[0];
    assign o_result.pred_rate_y = gyr_res[1];
    assign o_result.pred_rate_z = gyr_res[2];

endmodule

// ----- design/imp_checker.sv -----
// imp_checker: port-level assertions on latency and register read back, bound to the top level
// depends on imp_pkg and imu_measurement_predict

module imp_checker
    import imp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready
);

    // every taken item gives one result at the end of the pipeline
    a_item_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_done)
        else $error("item taken without its result seven cycles later");

    // no result without a matching item taken before it
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##7 !o_done)
        else $error("result without a matching item");

    // base mode reads back what was written
    a_base_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[ADDR_W-1:3] == REG_BASE_MODE)
        ##1 (psel && !pwrite && paddr[ADDR_W-1:3] == REG_BASE_MODE)
        |-> prdata[0] == $past(pwdata[0]))
        else $error("base mode read back mismatch");

    // mounting quaternion reads back what was written
    a_quat_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[ADDR_W-1:3] == REG_MOUNT_QUAT)
        ##1 (psel && !pwrite && paddr[ADDR_W-1:3] == REG_MOUNT_QUAT)
        |-> prdata == $past(pwdata))
        else $error("mounting quaternion read back mismatch");

endmodule

bind imu_measurement_predict imp_checker u_imp_checker (.*);

// ----- tb/imp_predict_monitor.sv -----
`timescale 1ns / 1ps
// imp_predict_monitor: watches the item, result and register channels of the imu predictor
// keeps its own register copy, predicts each result and compares; depends on imp_pkg

module imp_predict_monitor
    import imp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_in_item          i_item,
    input  logic              i_done,
    input  t_out_item         i_result,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output int                o_pending,
    output int                o_fail_count
);

    typedef struct packed {
        longint x;
        longint y;
        longint z;
    } t_v3;

    t_cfg      regs;
    t_out_item predicted_q[$];
    t_out_item want;
    int        result_no;

    function automatic t_v3 make_v3(t_q16 x, t_q16 y, t_q16 z);
        t_v3 v;
        v.x = x;
        v.y = y;
        v.z = z;
        return v;
    endfunction

    function automatic t_v3 unpack48(logic [47:0] p);
        return make_v3(p[47:32], p[31:16], p[15:0]);
    endfunction

    function automatic t_v3 vcross(t_v3 p, t_v3 q);
        t_v3 o;
        o.x = p.y * q.z - p.z * q.y;
        o.y = p.z * q.x - p.x * q.z;
        o.z = p.x * q.y - p.y * q.x;
        return o;
    endfunction

    // add half an lsb, then arithmetic shift (round half up)
    function automatic longint round_q(longint v, int k);
        return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic t_q16 clamp_q16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // v in q.16, result in q.8, not yet saturated
    function automatic t_v3 rotate_by_mount(t_v3 v, logic [63:0] q);
        t_v3    u;
        t_v3    c;
        t_v3    t;
        t_v3    ut;
        t_v3    o;
        longint s;
        s   = $signed(q[63:48]);
        u   = unpack48(q[47:0]);
        c   = vcross(u, v);
        t.x = round_q(c.x, 13);
        t.y = round_q(c.y, 13);
        t.z = round_q(c.z, 13);
        ut  = vcross(u, t);
        o.x = round_q(v.x * 16384 + s * t.x + ut.x, 22);
        o.y = round_q(v.y * 16384 + s * t.y + ut.y, 22);
        o.z = round_q(v.z * 16384 + s * t.z + ut.z, 22);
        return o;
    endfunction

    function automatic t_out_item predict_imu(t_in_item it, t_cfg c);
        t_out_item res;
        t_v3       a;
        t_v3       w;
        t_v3       al;
        t_v3       r;
        t_v3       wr;
        t_v3       ar;
        t_v3       wwr;
        t_v3       f;
        t_v3       wq;
        t_v3       ro;
        t_v3       bias;
        if (c.base_mode) begin
            res.pred_acc_x  = it.acc_x;
            res.pred_acc_y  = it.acc_y;
            res.pred_acc_z  = it.acc_z;
            res.pred_rate_x = it.rate_x;
            res.pred_rate_y = it.rate_y;
            res.pred_rate_z = it.rate_z;
            return res;
        end
        a   = make_v3(it.acc_x, it.acc_y, it.acc_z);
        w   = make_v3(it.rate_x, it.rate_y, it.rate_z);
        al  = make_v3(it.spin_acc_x, it.spin_acc_y, it.spin_acc_z);
        r   = unpack48(c.position_offset);
        ar  = vcross(al, r);
        wr  = vcross(w, r);
        wwr = vcross(w, wr);
        // lever arm sum in q.28, down to q.16
        f.x = round_q(a.x * 1048576 + ar.x * 256 + wwr.x, 12);
        f.y = round_q(a.y * 1048576 + ar.y * 256 + wwr.y, 12);
        f.z = round_q(a.z * 1048576 + ar.z * 256 + wwr.z, 12);
        ro   = rotate_by_mount(f, c.mount_quaternion);
        bias = unpack48(c.accel_bias);
        res.pred_acc_x = clamp_q16(ro.x + bias.x);
        res.pred_acc_y = clamp_q16(ro.y + bias.y);
        res.pred_acc_z = clamp_q16(ro.z + bias.z);
        wq.x = w.x * 256;
        wq.y = w.y * 256;
        wq.z = w.z * 256;
        ro   = rotate_by_mount(wq, c.mount_quaternion);
        bias = unpack48(c.gyro_bias);
        res.pred_rate_x = clamp_q16(ro.x + bias.x);
        res.pred_rate_y = clamp_q16(ro.y + bias.y);
        res.pred_rate_z = clamp_q16(ro.z + bias.z);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic check_field(string name, t_q16 got, t_q16 exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("result %0d %s got %0d wanted %0d",
                                      result_no, name, got, exp_val));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.base_mode        = 1'b0;
            regs.position_offset  = '0;
            regs.mount_quaternion = QUAT_RESET;
            regs.accel_bias       = '0;
            regs.gyro_bias        = '0;
            predicted_q.delete();
            result_no    = 0;
            o_fail_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:3])
                    REG_BASE_MODE:  regs.base_mode        = i_pwdata[0];
                    REG_POS_OFFSET: regs.position_offset  = i_pwdata[47:0];
                    REG_MOUNT_QUAT: regs.mount_quaternion = i_pwdata[63:0];
                    REG_ACCEL_BIAS: regs.accel_bias       = i_pwdata[47:0];
                    REG_GYRO_BIAS:  regs.gyro_bias        = i_pwdata[47:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                predicted_q.push_back(predict_imu(i_item, regs));
            if (i_done) begin
                if (predicted_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no item outstanding", result_no));
                end else begin
                    want = predicted_q.pop_front();
                    check_field("pred_acc_x", i_result.pred_acc_x, want.pred_acc_x);
                    check_field("pred_acc_y", i_result.pred_acc_y, want.pred_acc_y);
                    check_field("pred_acc_z", i_result.pred_acc_z, want.pred_acc_z);
                    check_field("pred_rate_x", i_result.pred_rate_x, want.pred_rate_x);
                    check_field("pred_rate_y", i_result.pred_rate_y, want.pred_rate_y);
                    check_field("pred_rate_z", i_result.pred_rate_z, want.pred_rate_z);
                end
                result_no++;
            end
        end
        o_pending <= predicted_q.size();
    end

endmodule

// ----- tb/imu_measurement_predict_test.sv -----
`timescale 1ns / 1ps
// imu_measurement_predict_test: drives items and register writes into the imu predictor
// and gives the verdict; depends on imp_pkg, imp_predict_monitor and the design

module imu_measurement_predict_test;
    import imp_pkg::*;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    t_in_item          i_item  = '0;
    logic              o_done;
    t_out_item         o_result;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                pending;
    int                fail_count;

    imu_measurement_predict DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    imp_predict_monitor monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_done       (o_done),
        .i_result     (o_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // signed value spread evenly over [-span, span)
    function automatic t_q16 rand_near(int span);
        return 16'($urandom_range(0, 2 * span - 1) - span);
    endfunction

    // mostly moderate values, with extremes and full-range noise mixed in
    function automatic t_q16 rand_q16();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3, 4: return 16'($urandom);
            default: return rand_near(1024);
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        for (int f = 0; f < 9; f++)
            it[$bits(t_in_item) - 1 - 16 * f -: 16] = rand_q16();
        return it;
    endfunction

    // field extremes, bit patterns, then one field at a time at full scale
    function automatic t_in_item directed_item(int k);
        t_in_item it;
        case (k)
            0:       it = '0;
            1:       it = {9{16'h7FFF}};
            2:       it = {9{16'h8000}};
            3:       it = {9{16'h5555}};
            4:       it = {9{16'hAAAA}};
            default: begin
                it = '0;
                it[$bits(t_in_item) - 1 - 16 * (k - 5) -: 16] = (k % 2) ? 16'h7FFF : 16'h8000;
            end
        endcase
        return it;
    endfunction

    function automatic logic [47:0] rand_vec48(int span);
        if ($urandom_range(0, 2) == 0)
            return {16'($urandom), $urandom};
        return {rand_near(span), rand_near(span), rand_near(span)};
    endfunction

    // register sets: saturating extremes first, then a zero quaternion, then random
    function automatic t_cfg pick_settings(int kind);
        t_cfg c;
        case (kind)
            0: begin
                c.base_mode        = 1'b0;
                c.position_offset  = {3{16'h7FFF}};
                c.mount_quaternion = {4{16'h7FFF}};
                c.accel_bias       = {3{16'h7FFF}};
                c.gyro_bias        = {3{16'h7FFF}};
            end
            1: begin
                c.base_mode        = 1'b0;
                c.position_offset  = {3{16'h8000}};
                c.mount_quaternion = {4{16'h8000}};
                c.accel_bias       = {3{16'h8000}};
                c.gyro_bias        = {3{16'h8000}};
            end
            2: begin
                // zero quaternion: the vector passes unrotated, plus the biases
                c.base_mode        = 1'b0;
                c.position_offset  = rand_vec48(4096);
                c.mount_quaternion = '0;
                c.accel_bias       = rand_vec48(512);
                c.gyro_bias        = rand_vec48(512);
            end
            default: begin
                c.base_mode       = ($urandom_range(0, 5) == 0);
                c.position_offset = rand_vec48(4096);
                case ($urandom_range(0, 4))
                    0:       c.mount_quaternion = {$urandom, $urandom};
                    1:       c.mount_quaternion = QUAT_RESET;
                    // 90 deg about z
                    2:       c.mount_quaternion = {16'h2D41, 16'h0000, 16'h0000, 16'h2D41};
                    // 180 deg about x
                    3:       c.mount_quaternion = {16'h0000, 16'h4000, 16'h0000, 16'h0000};
                    default: c.mount_quaternion = {rand_near(16384), rand_near(16384),
                                                   rand_near(16384), rand_near(16384)};
                endcase
                c.accel_bias = rand_vec48(512);
                c.gyro_bias  = rand_vec48(512);
            end
        endcase
        return c;
    endfunction

    // setup phase, access phase, then an idle phase so the next write starts clean
    task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop sending and wait until every outstanding result has come back
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        // pipeline is seven deep, leave some margin
        repeat (10) @(posedge i_clk);
    endtask

    // every register written, with junk above the register width
    task automatic apply_settings(t_cfg c);
        drain();
        write_reg(REG_BASE_MODE, {$urandom, 31'($urandom), c.base_mode});
        write_reg(REG_POS_OFFSET, {16'($urandom), c.position_offset});
        write_reg(REG_MOUNT_QUAT, c.mount_quaternion);
        write_reg(REG_ACCEL_BIAS, {16'($urandom), c.accel_bias});
        write_reg(REG_GYRO_BIAS, {16'($urandom), c.gyro_bias});
    endtask

    // start stays high through a burst; the item is taken when busy is low at the edge
    task automatic send_item(t_in_item it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic random_phase(int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            // mostly short bursts, now and then a long unbroken stretch
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            for (int b = 0; b < burst && left > 0; b++) begin
                send_item(rand_item());
                left--;
            end
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 30) == 0) begin
                // let the pipeline empty out completely mid-phase
                start <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end else if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin : stimulus
        t_cfg c;
        int   guard;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: identity mount, no offset or bias, so items pass through
        for (int k = 0; k < 14; k++)
            send_item(directed_item(k));

        // base mode with wild registers that must all be ignored
        c = pick_settings(3);
        c.base_mode = 1'b1;
        apply_settings(c);
        // writes past the register list must not land anywhere
        for (int i = REG_GYRO_BIAS + 1; i < 8; i++)
            write_reg(3'(i), {$urandom, $urandom});
        for (int k = 1; k < 5; k++)
            send_item(directed_item(k));
        send_item(rand_item());

        for (int p = 0; p < 10; p++) begin
            apply_settings(pick_settings(p));
            random_phase(153);
        end

        start <= 1'b0;
        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (pending != 0 && guard < 1000);
        repeat (20) @(posedge i_clk);

        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
